// ===== rtl/point_in_tetrahedron_test_core_defines.svh =====
// assertion macros used by the point-in-tetrahedron test rtl
`ifndef POINT_IN_TETRAHEDRON_TEST_CORE_DEFINES_SVH
`define POINT_IN_TETRAHEDRON_TEST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define PITT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PITT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PITT_ASSERT(lbl, prop, msg)
`define PITT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/pitt_pkg.sv =====
// shared types, widths and codes of the point-in-tetrahedron test
`timescale 1ns / 1ps
package pitt_pkg;
	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int OP_W    = 27;
	localparam int PROD_W  = 2 * OP_W;
	localparam int SPLIT   = 26;
	localparam int M_W     = 2 * SPLIT;
	localparam int D_W     = 80;
	localparam int TOL_W   = 16;
	localparam int REF_W   = D_W + TOL_W;
	localparam int CMP_W   = REF_W + 4;
	localparam int OP_CW   = 4;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_TOL = 1'b0;

	typedef struct packed {
		logic               cmd;
		logic [1:0]         slot;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} item_t;

	function automatic logic signed [DIFF_W-1:0] diff(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
	endfunction

	function automatic logic signed [OP_W-1:0] sx_op(input logic signed [DIFF_W-1:0] v);
		return {{(OP_W-DIFF_W){v[DIFF_W-1]}}, v};
	endfunction
endpackage

// ===== rtl/pitt_front.sv =====
// front end: input transfer queue ahead of the compute engine
`timescale 1ns / 1ps
module pitt_front import pitt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t in_item,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);
	item_t      buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ===== rtl/pitt_back.sv =====
// back end: vertex store and shared-multiplier volume sequencer
`timescale 1ns / 1ps
`include "point_in_tetrahedron_test_core_defines.svh"
module pitt_back import pitt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             q_pop,
	input  logic [TOL_W-1:0] tolerance,
	input  logic             res_ready,
	output logic             res_push,
	output logic             res_inside
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DET    = 3'd1;
	localparam logic [2:0] ST_WAIT   = 3'd2;
	localparam logic [2:0] ST_REF    = 3'd3;
	localparam logic [2:0] ST_DRAIN1 = 3'd4;
	localparam logic [2:0] ST_DRAIN2 = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	typedef struct packed {
		logic             vld;
		logic             is_ref;
		logic [2:0]       det;
		logic [OP_CW-1:0] op;
	} tag_t;

	logic [2:0]         state_q;
	logic [2:0]         det_q;
	logic [OP_CW-1:0]   op_q;
	logic [COORD_W-1:0] vtx_q [4][3];
	logic [COORD_W-1:0] qv_q [3];
	logic               inside_q;

	logic signed [M_W-1:0]    m_q [3];
	logic signed [D_W-1:0]    det_acc_q;
	logic [REF_W-1:0]         ref_q;
	logic signed [PROD_W-1:0] prod_s1;
	tag_t                     tag_s1;
	logic                     chk_s2;

	logic signed [DIFF_W-1:0] d1 [3], d2 [3], d3 [3], dq [3], e1 [3], e2 [3], e3 [3];
	logic signed [DIFF_W-1:0] va [3], vb [3], vc [3];
	logic signed [OP_W-1:0]   mul_a, mul_b;
	logic [D_W-1:0]           absv;
	logic [SPLIT-1:0]         chunk;
	logic                     issue;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d1[k] = diff(vtx_q[1][k], vtx_q[0][k]);
			d2[k] = diff(vtx_q[2][k], vtx_q[0][k]);
			d3[k] = diff(vtx_q[3][k], vtx_q[0][k]);
			dq[k] = diff(qv_q[k], vtx_q[0][k]);
			e1[k] = diff(vtx_q[1][k], qv_q[k]);
			e2[k] = diff(vtx_q[2][k], qv_q[k]);
			e3[k] = diff(vtx_q[3][k], qv_q[k]);
		end
		case (det_q)
			3'd0: begin va = d1; vb = d2; vc = d3; end
			3'd1: begin va = e1; vb = e2; vc = e3; end
			3'd2: begin va = dq; vb = d2; vc = d3; end
			3'd3: begin va = d1; vb = dq; vc = d3; end
			default: begin va = d1; vb = d2; vc = dq; end
		endcase
	end

	assign absv  = det_acc_q[D_W-1] ? D_W'(-det_acc_q) : D_W'(det_acc_q);
	assign issue = (state_q == ST_DET) || (state_q == ST_REF);

	always_comb begin
		chunk = absv[SPLIT-1:0];
		case (op_q[1:0])
			2'd1:    chunk = absv[2*SPLIT-1:SPLIT];
			2'd2:    chunk = absv[3*SPLIT-1:2*SPLIT];
			default: chunk = absv[SPLIT-1:0];
		endcase
		mul_a = sx_op(vb[1]);
		mul_b = sx_op(vc[2]);
		if (state_q == ST_REF) begin
			mul_a = {{(OP_W-TOL_W){1'b0}}, tolerance};
			mul_b = {{(OP_W-SPLIT){1'b0}}, chunk};
		end else begin
			case (op_q)
				4'd0: begin mul_a = sx_op(vb[1]); mul_b = sx_op(vc[2]); end
				4'd1: begin mul_a = sx_op(vb[2]); mul_b = sx_op(vc[1]); end
				4'd2: begin mul_a = sx_op(vb[0]); mul_b = sx_op(vc[2]); end
				4'd3: begin mul_a = sx_op(vb[2]); mul_b = sx_op(vc[0]); end
				4'd4: begin mul_a = sx_op(vb[0]); mul_b = sx_op(vc[1]); end
				4'd5: begin mul_a = sx_op(vb[1]); mul_b = sx_op(vc[0]); end
				4'd6: begin mul_a = sx_op(va[0]); mul_b = {m_q[0][M_W-1], m_q[0][M_W-1:SPLIT]}; end
				4'd7: begin mul_a = sx_op(va[0]); mul_b = {1'b0, m_q[0][SPLIT-1:0]}; end
				4'd8: begin mul_a = sx_op(va[1]); mul_b = {m_q[1][M_W-1], m_q[1][M_W-1:SPLIT]}; end
				4'd9: begin mul_a = sx_op(va[1]); mul_b = {1'b0, m_q[1][SPLIT-1:0]}; end
				4'd10: begin mul_a = sx_op(va[2]); mul_b = {m_q[2][M_W-1], m_q[2][M_W-1:SPLIT]}; end
				4'd11: begin mul_a = sx_op(va[2]); mul_b = {1'b0, m_q[2][SPLIT-1:0]}; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign res_push   = (state_q == ST_DONE) && res_ready;
	assign res_inside = inside_q;

	// control sequencer and vertex store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			det_q   <= 3'd0;
			op_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				for (int k = 0; k < 3; k++) begin
					vtx_q[i][k] <= '0;
				end
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.cmd == CMD_LOAD) begin
							vtx_q[q_item.slot][0] <= q_item.x;
							vtx_q[q_item.slot][1] <= q_item.y;
							vtx_q[q_item.slot][2] <= q_item.z;
						end else begin
							det_q   <= 3'd0;
							op_q    <= '0;
							state_q <= ST_DET;
						end
					end
				end
				ST_DET: begin
					if (op_q == 4'd11) begin
						op_q <= '0;
						if (det_q == 3'd0) begin
							state_q <= ST_WAIT;
						end else if (det_q == 3'd4) begin
							state_q <= ST_DRAIN1;
						end else begin
							det_q <= det_q + 1'b1;
						end
					end else begin
						op_q <= op_q + 1'b1;
					end
				end
				ST_WAIT: state_q <= ST_REF;
				ST_REF: begin
					if (op_q == 4'd2) begin
						op_q    <= '0;
						det_q   <= 3'd1;
						state_q <= ST_DET;
					end else begin
						op_q <= op_q + 1'b1;
					end
				end
				ST_DRAIN1: state_q <= ST_DRAIN2;
				ST_DRAIN2: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			chk_s2 <= 1'b0;
		end else begin
			tag_s1.vld    <= issue;
			tag_s1.is_ref <= (state_q == ST_REF);
			tag_s1.det    <= det_q;
			tag_s1.op     <= op_q;
			chk_s2        <= tag_s1.vld && !tag_s1.is_ref && (tag_s1.op == 4'd11)
				&& (tag_s1.det != 3'd0);
		end
	end

	// datapath: multiply, accumulate, compare
	always_ff @(posedge clk) begin
		logic signed [D_W-1:0]   pe_d;
		logic signed [D_W-1:0]   term;
		logic [REF_W-1:0]        pe_r;
		logic signed [CMP_W-1:0] s;
		pe_d = {{(D_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		term = tag_s1.op[0] ? pe_d : (pe_d <<< SPLIT);
		pe_r = {{(REF_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		s = ({{(CMP_W-D_W){det_acc_q[D_W-1]}}, det_acc_q} <<< TOL_W)
			+ $signed({{(CMP_W-REF_W){1'b0}}, ref_q});

		prod_s1 <= mul_a * mul_b;
		if (q_pop && q_item.cmd == CMD_QUERY) begin
			qv_q[0]  <= q_item.x;
			qv_q[1]  <= q_item.y;
			qv_q[2]  <= q_item.z;
			inside_q <= 1'b1;
		end else if (chk_s2 && s[CMP_W-1]) begin
			inside_q <= 1'b0;
		end
		if (tag_s1.vld) begin
			if (tag_s1.is_ref) begin
				case (tag_s1.op[1:0])
					2'd0:    ref_q <= pe_r;
					2'd1:    ref_q <= ref_q + (pe_r << SPLIT);
					default: ref_q <= ref_q + (pe_r << (2 * SPLIT));
				endcase
			end else begin
				case (tag_s1.op)
					4'd0, 4'd2, 4'd4: m_q[tag_s1.op[2:1]] <= prod_s1[M_W-1:0];
					4'd1, 4'd3, 4'd5: m_q[tag_s1.op[2:1]] <= m_q[tag_s1.op[2:1]]
						- prod_s1[M_W-1:0];
					4'd6:       det_acc_q <= term;
					4'd8, 4'd9: det_acc_q <= det_acc_q - term;
					default:    det_acc_q <= det_acc_q + term;
				endcase
			end
		end
	end

	`PITT_ASSERT(a_ref_after_wait, (state_q == ST_REF && op_q == '0) |-> $past(state_q) == ST_WAIT, "tolerance product started before reference volume settled")
	`PITT_ASSERT(a_chk_in_drain_or_det, chk_s2 |-> (state_q == ST_DET || state_q == ST_DRAIN2), "volume check outside of query sequence")
	`PITT_ASSERT_ALWAYS(a_no_pop_busy, q_pop |-> (state_q == ST_IDLE && !res_push), "queue popped while engine busy")
endmodule

// ===== rtl/point_in_tetrahedron_test_core.sv =====
// top level of the point-in-tetrahedron test: config port, queue, engine, output register
`timescale 1ns / 1ps
// Point-in-tetrahedron test by signed volumes, exact in wide integers. A load item
// (cmd 0) stores one vertex in slot 0..3 and gives no result; a query item (cmd 1)
// gives one transfer on the output with inside_res set when no sub-volume falls below
// -tolerance/65536 times the absolute reference volume. Items queue in a two-entry
// front buffer, so the input keeps taking transfers while the engine works, until
// both entries are full. For a query, five 3x3 determinants and the tolerance
// product go as 63 partial products through one shared 27x27 signed multiplier, one
// product per cycle, then pipeline drain and handoff. The result sits in an output
// register, so the engine takes the next item while the last result waits out a
// stall. tolerance is the only register, at byte address 0, unsigned Q0.16, reset 0;
// the user must write it only while the block is idle, which the block does not enforce.
module point_in_tetrahedron_test_core import pitt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic [1:0]                slot,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      inside_res
);
	logic [TOL_W-1:0] tol_q;
	item_t            in_item;
	item_t            q_item;
	logic             q_valid;
	logic             q_pop;
	logic             res_ready;
	logic             res_push;
	logic             res_inside;
	logic             out_valid_q;
	logic             inside_q;

	// apb: always ready, one register indexed by the word address bit
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TOL) ? {{(32-TOL_W){1'b0}}, tol_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOL) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	assign in_item = '{cmd: cmd, slot: slot, x: coord_x, y: coord_y, z: coord_z};

	// front end: buffers incoming transfers
	pitt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// back end: vertex store and volume engine
	pitt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.tolerance  (tol_q),
		.res_ready  (res_ready),
		.res_push   (res_push),
		.res_inside (res_inside)
	);

	// output register: frees the engine while a result waits
	assign res_ready  = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			inside_q <= res_inside;
		end
	end
endmodule
